/* design/mrb_pkg.sv */
// shared codes, widths and controller/datapath interface structs
// for the register bank; no dependencies
package mrb_pkg;

    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE1 = 2'd1;
    localparam logic [1:0] CMD_WRITEM = 2'd2;

    localparam logic [1:0] TBL_COIL = 2'd0;
    localparam logic [1:0] TBL_DISC = 2'd1;
    localparam logic [1:0] TBL_IREG = 2'd2;
    localparam logic [1:0] TBL_HOLD = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ADDR  = 2'd1;
    localparam logic [1:0] ST_VALUE = 2'd2;

    localparam logic [1:0] CFG_COIL_SIZE = 2'd0;
    localparam logic [1:0] CFG_DISC_SIZE = 2'd1;
    localparam logic [1:0] CFG_IREG_SIZE = 2'd2;
    localparam logic [1:0] CFG_HOLD_SIZE = 2'd3;

    localparam int CFG_W  = 12;
    localparam int SIZE_W = 17;

    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;

    typedef struct packed {
        logic       load;
        logic       run_cancel;
        logic       run_open;
        logic       run_write;
        logic       run_advance;
        logic       wr_single;
        logic       elem_clear;
        logic       elem_inc;
        logic       rd_capture;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_word;
        logic       out_last;
    } t_ctl_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] read_err;
        logic [1:0] wr1_err;
        logic       run_open;
        logic       open_zero;
        logic       take_last;
        logic       run_last;
        logic [1:0] run_err;
        logic       elem_last;
        logic       word_end;
        logic       clearing;
    } t_dp_stat;

endpackage

/* design/mrb_datapath.sv */
// datapath: the four stores, config sizes, request latch, run state,
// read word assembly and output register; uses mrb_pkg
module mrb_datapath import mrb_pkg::*; #(
    parameter int COIL_MAX         = 2048,
    parameter int DISCRETE_MAX     = 2048,
    parameter int HOLDING_MAX      = 256,
    parameter int INPUT_REG_MAX    = 256,
    parameter int MAX_READ_RESULTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl_cmd         i_cmd,
    output t_dp_stat         o_stat,
    input  logic [1:0]       i_command,
    input  logic [1:0]       i_table_req,
    input  logic [15:0]      i_start_req,
    input  logic [10:0]      i_count,
    input  logic [15:0]      i_value,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output logic [1:0]       o_status,
    output logic [15:0]      o_data,
    output logic             o_last
);

    localparam int CAW = (COIL_MAX > 1) ? $clog2(COIL_MAX) : 1;
    localparam int DAW = (DISCRETE_MAX > 1) ? $clog2(DISCRETE_MAX) : 1;
    localparam int IAW = (INPUT_REG_MAX > 1) ? $clog2(INPUT_REG_MAX) : 1;
    localparam int HAW = (HOLDING_MAX > 1) ? $clog2(HOLDING_MAX) : 1;
    localparam int MAX_BD = (COIL_MAX > DISCRETE_MAX) ? COIL_MAX : DISCRETE_MAX;
    localparam int MAX_WD = (HOLDING_MAX > INPUT_REG_MAX) ? HOLDING_MAX : INPUT_REG_MAX;
    localparam int CLR_N  = (MAX_BD > MAX_WD) ? MAX_BD : MAX_WD;
    localparam int CLW    = $clog2(CLR_N);

    localparam logic [SIZE_W-1:0] COIL_D = SIZE_W'(COIL_MAX);
    localparam logic [SIZE_W-1:0] DISC_D = SIZE_W'(DISCRETE_MAX);
    localparam logic [SIZE_W-1:0] IREG_D = SIZE_W'(INPUT_REG_MAX);
    localparam logic [SIZE_W-1:0] HOLD_D = SIZE_W'(HOLDING_MAX);
    localparam logic [CLW:0] COIL_LIM = (CLW+1)'(COIL_MAX);
    localparam logic [CLW:0] DISC_LIM = (CLW+1)'(DISCRETE_MAX);
    localparam logic [CLW:0] IREG_LIM = (CLW+1)'(INPUT_REG_MAX);
    localparam logic [CLW:0] HOLD_LIM = (CLW+1)'(HOLDING_MAX);
    localparam logic [CLW-1:0] CLR_END = CLW'(CLR_N - 1);
    localparam logic [11:0] BIT_LIM  = 12'(MAX_READ_RESULTS * 16);
    localparam logic [11:0] WORD_LIM = 12'(MAX_READ_RESULTS);

    // stores
    logic r_coil_mem [COIL_MAX];
    logic r_disc_mem [DISCRETE_MAX];
    logic [15:0] r_ireg_mem [INPUT_REG_MAX];
    logic [15:0] r_hold_mem [HOLDING_MAX];
    logic r_coil_rd, r_disc_rd;
    logic [15:0] r_ireg_rd, r_hold_rd;

    logic [CFG_W-1:0] r_cfg_coil, r_cfg_disc;
    logic [8:0]       r_cfg_ireg, r_cfg_hold;

    logic [1:0]  r_cmd, r_tbl;
    logic [15:0] r_start, r_val;
    logic [10:0] r_cnt;

    logic [10:0] r_run_rem;
    logic [15:0] r_run_ptr;
    logic [1:0]  r_run_err;

    logic [10:0] r_elem;
    logic [15:0] r_word;
    logic [1:0]  r_out_status;
    logic [15:0] r_out_data;
    logic        r_out_last;

    logic           r_clearing;
    logic [CLW-1:0] r_clr_idx;

    logic [SIZE_W-1:0] sz_coil, sz_disc, sz_ireg, sz_hold, size, rng_end;
    logic              bits, too_many, in_store, wr_en;
    logic [SIZE_W-1:0] rd_addr;
    logic [15:0]       run_idx, wr_idx, n_word;
    logic              wr_bit, rd_bit;
    logic [15:0]       rd_word;
    logic [4:0]        take;
    logic              coil_we, disc_we, ireg_we, hold_we;
    logic [CAW-1:0]    coil_wa;
    logic [DAW-1:0]    disc_wa;
    logic [IAW-1:0]    ireg_wa;
    logic [HAW-1:0]    hold_wa;

    always_comb begin
        sz_coil = (SIZE_W'(r_cfg_coil) < COIL_D) ? SIZE_W'(r_cfg_coil) : COIL_D;
        sz_disc = (SIZE_W'(r_cfg_disc) < DISC_D) ? SIZE_W'(r_cfg_disc) : DISC_D;
        sz_ireg = (SIZE_W'(r_cfg_ireg) < IREG_D) ? SIZE_W'(r_cfg_ireg) : IREG_D;
        sz_hold = (SIZE_W'(r_cfg_hold) < HOLD_D) ? SIZE_W'(r_cfg_hold) : HOLD_D;
        case (r_tbl)
            TBL_COIL: size = sz_coil;
            TBL_DISC: size = sz_disc;
            TBL_IREG: size = sz_ireg;
            default:  size = sz_hold;
        endcase
        bits     = ~r_tbl[1];
        rng_end  = {1'b0, r_start} + SIZE_W'(r_cnt);
        too_many = bits ? ({1'b0, r_cnt} > BIT_LIM) : ({1'b0, r_cnt} > WORD_LIM);
        rd_addr  = {1'b0, r_start} + SIZE_W'(r_elem);

        take = bits ? ((r_run_rem < 11'd16) ? r_run_rem[4:0] : 5'd16) : 5'd1;

        run_idx  = r_run_ptr + 16'(r_elem);
        wr_idx   = i_cmd.wr_single ? r_start : run_idx;
        in_store = {1'b0, wr_idx} < size;
        wr_en    = (i_cmd.wr_single || (i_cmd.run_write && r_run_err == ST_OK)) && in_store;
        wr_bit   = i_cmd.wr_single ? (r_val == COIL_ON) : r_val[r_elem[3:0]];

        rd_bit  = (r_tbl == TBL_COIL) ? r_coil_rd : r_disc_rd;
        rd_word = (r_tbl == TBL_IREG) ? r_ireg_rd : r_hold_rd;
        n_word  = bits ? (((r_elem[3:0] == 4'd0) ? 16'h0000 : r_word)
                          | (16'(rd_bit) << r_elem[3:0]))
                       : rd_word;

        // clearing pass owns the write ports until it finishes
        coil_we = r_clearing ? ({1'b0, r_clr_idx} < COIL_LIM) : (wr_en && r_tbl == TBL_COIL);
        disc_we = r_clearing ? ({1'b0, r_clr_idx} < DISC_LIM) : (wr_en && r_tbl == TBL_DISC);
        ireg_we = r_clearing ? ({1'b0, r_clr_idx} < IREG_LIM) : (wr_en && r_tbl == TBL_IREG);
        hold_we = r_clearing ? ({1'b0, r_clr_idx} < HOLD_LIM) : (wr_en && r_tbl == TBL_HOLD);
        coil_wa = r_clearing ? r_clr_idx[CAW-1:0] : wr_idx[CAW-1:0];
        disc_wa = r_clearing ? r_clr_idx[DAW-1:0] : wr_idx[DAW-1:0];
        ireg_wa = r_clearing ? r_clr_idx[IAW-1:0] : wr_idx[IAW-1:0];
        hold_wa = r_clearing ? r_clr_idx[HAW-1:0] : wr_idx[HAW-1:0];
    end

    always_comb begin
        o_stat.cmd = r_cmd;
        if (r_cnt == 11'd0 || too_many) begin
            o_stat.read_err = ST_VALUE;
        end else if (rng_end > size) begin
            o_stat.read_err = ST_ADDR;
        end else begin
            o_stat.read_err = ST_OK;
        end
        if ({1'b0, r_start} >= size) begin
            o_stat.wr1_err = ST_ADDR;
        end else if (bits && r_val != COIL_ON && r_val != COIL_OFF) begin
            o_stat.wr1_err = ST_VALUE;
        end else begin
            o_stat.wr1_err = ST_OK;
        end
        o_stat.run_open  = (r_run_rem == 11'd0);
        o_stat.open_zero = (r_run_rem == 11'd0) && (r_cnt == 11'd0);
        o_stat.take_last = ((r_elem + 11'd1) == 11'(take));
        o_stat.run_last  = (r_run_rem == 11'(take));
        o_stat.run_err   = r_run_err;
        o_stat.elem_last = ((r_elem + 11'd1) == r_cnt);
        o_stat.word_end  = !bits || (r_elem[3:0] == 4'hF);
        o_stat.clearing  = r_clearing;
    end

    always_ff @(posedge i_clk) begin
        if (coil_we) r_coil_mem[coil_wa] <= r_clearing ? 1'b0 : wr_bit;
        if (disc_we) r_disc_mem[disc_wa] <= r_clearing ? 1'b0 : wr_bit;
        if (ireg_we) r_ireg_mem[ireg_wa] <= r_clearing ? 16'h0000 : r_val;
        if (hold_we) r_hold_mem[hold_wa] <= r_clearing ? 16'h0000 : r_val;
        r_coil_rd <= r_coil_mem[rd_addr[CAW-1:0]];
        r_disc_rd <= r_disc_mem[rd_addr[DAW-1:0]];
        r_ireg_rd <= r_ireg_mem[rd_addr[IAW-1:0]];
        r_hold_rd <= r_hold_mem[rd_addr[HAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_cfg_coil <= 12'd2048;
            r_cfg_disc <= 12'd2048;
            r_cfg_ireg <= 9'd256;
            r_cfg_hold <= 9'd256;
            r_run_rem  <= '0;
            r_run_ptr  <= '0;
            r_run_err  <= ST_OK;
        end else begin
            if (r_clearing) begin
                if (r_clr_idx == CLR_END) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COIL_SIZE: r_cfg_coil <= i_cfg_wdata;
                    CFG_DISC_SIZE: r_cfg_disc <= i_cfg_wdata;
                    CFG_IREG_SIZE: r_cfg_ireg <= i_cfg_wdata[8:0];
                    CFG_HOLD_SIZE: r_cfg_hold <= i_cfg_wdata[8:0];
                    default: ;
                endcase
            end
            if (i_cmd.run_cancel) begin
                r_run_rem <= '0;
            end else if (i_cmd.run_open) begin
                r_run_err <= (rng_end > size) ? ST_ADDR : ST_OK;
                r_run_ptr <= r_start;
                r_run_rem <= r_cnt;
            end else if (i_cmd.run_advance) begin
                r_run_ptr <= r_run_ptr + 16'(take);
                r_run_rem <= r_run_rem - 11'(take);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_tbl   <= i_table_req;
            r_start <= i_start_req;
            r_cnt   <= i_count;
            r_val   <= i_value;
        end
        if (i_cmd.elem_clear) begin
            r_elem <= '0;
        end else if (i_cmd.elem_inc) begin
            r_elem <= r_elem + 11'd1;
        end
        if (i_cmd.rd_capture) r_word <= n_word;
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_data   <= i_cmd.out_word ? n_word : 16'h0000;
            r_out_last   <= i_cmd.out_last;
        end
    end

    assign o_status = r_out_status;
    assign o_data   = r_out_data;
    assign o_last   = r_out_last;

endmodule

/* design/mrb_ctrl.sv */
// controller state machine: sequences request decode, element loops
// and result handoff; uses mrb_pkg
module mrb_ctrl import mrb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_RUN     = 3'd2;
    localparam logic [2:0] S_RD_ADDR = 3'd3;
    localparam logic [2:0] S_RD_DATA = 3'd4;
    localparam logic [2:0] S_OUT     = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_more, n_more;
    logic       ready;

    assign ready   = (r_state == S_IDLE) && !i_stat.clearing;
    assign o_stall = !ready;
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_more  = r_more;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_more = 1'b0;
                case (i_stat.cmd)
                    CMD_READ: begin
                        o_cmd.run_cancel = 1'b1;
                        if (i_stat.read_err != ST_OK) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_status = i_stat.read_err;
                            o_cmd.out_last   = 1'b1;
                            n_state          = S_OUT;
                        end else begin
                            o_cmd.elem_clear = 1'b1;
                            n_state          = S_RD_ADDR;
                        end
                    end
                    CMD_WRITE1: begin
                        o_cmd.run_cancel = 1'b1;
                        o_cmd.wr_single  = (i_stat.wr1_err == ST_OK);
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = i_stat.wr1_err;
                        o_cmd.out_last   = 1'b1;
                        n_state          = S_OUT;
                    end
                    CMD_WRITEM: begin
                        if (i_stat.open_zero) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_status = ST_VALUE;
                            o_cmd.out_last   = 1'b1;
                            n_state          = S_OUT;
                        end else begin
                            o_cmd.run_open   = i_stat.run_open;
                            o_cmd.elem_clear = 1'b1;
                            n_state          = S_RUN;
                        end
                    end
                    default: begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = ST_VALUE;
                        o_cmd.out_last   = 1'b1;
                        n_state          = S_OUT;
                    end
                endcase
            end
            S_RUN: begin
                o_cmd.run_write = 1'b1;
                if (i_stat.take_last) begin
                    o_cmd.run_advance = 1'b1;
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_status  = i_stat.run_err;
                    o_cmd.out_last    = i_stat.run_last;
                    n_state           = S_OUT;
                end else begin
                    o_cmd.elem_inc = 1'b1;
                end
            end
            S_RD_ADDR: begin
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                o_cmd.rd_capture = 1'b1;
                o_cmd.elem_inc   = 1'b1;
                if (i_stat.word_end || i_stat.elem_last) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    o_cmd.out_word   = 1'b1;
                    o_cmd.out_last   = i_stat.elem_last;
                    n_more           = !i_stat.elem_last;
                    n_state          = S_OUT;
                end else begin
                    n_state = S_RD_ADDR;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = r_more ? S_RD_ADDR : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_more  <= n_more;
        end
    end

endmodule

/* design/modbus_register_bank.sv */
// top level of the register bank: controller plus datapath
// depends on mrb_pkg, mrb_ctrl and mrb_datapath
// lone results (errors, write single) go from the check state straight to the output register
// reads: each element is addressed, then captured; a result per 16-bit word (or register)
// write-multiple chunk: elements written in the run state; one request in flight at a time
// reset: synchronous; then a clearing pass over the max store depth (2048 entries by default)
module modbus_register_bank import mrb_pkg::*; #(
    parameter int COIL_MAX         = 2048,
    parameter int DISCRETE_MAX     = 2048,
    parameter int HOLDING_MAX      = 256,
    parameter int INPUT_REG_MAX    = 256,
    parameter int MAX_READ_RESULTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_command,
    input  logic [1:0]       i_table_req,
    input  logic [15:0]      i_start_req,
    input  logic [10:0]      i_count,
    input  logic [15:0]      i_value,
    // result channel
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_data,
    output logic             o_last,
    // size registers
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    // command bundle from the fsm, status bundle back from the datapath
    t_ctl_cmd ctl_cmd;
    t_dp_stat dp_stat;

    // the fsm only takes a request in idle and once the stores are cleared;
    // each result sits in the output register until the far side takes it
    mrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (dp_stat),
        .o_cmd   (ctl_cmd)
    );

    // stores are single write / single registered read memories; bit tables
    // are walked one element per read, packed lsb first into the result word
    mrb_datapath #(
        .COIL_MAX         (COIL_MAX),
        .DISCRETE_MAX     (DISCRETE_MAX),
        .HOLDING_MAX      (HOLDING_MAX),
        .INPUT_REG_MAX    (INPUT_REG_MAX),
        .MAX_READ_RESULTS (MAX_READ_RESULTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .o_stat      (dp_stat),
        .i_command   (i_command),
        .i_table_req (i_table_req),
        .i_start_req (i_start_req),
        .i_count     (i_count),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_last      (o_last)
    );

endmodule

/* design/mrb_checker.sv */
// port-level checker for the register bank, bound to the top level
// depends on mrb_pkg
module mrb_checker import mrb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [15:0] o_data,
    input logic        o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data) && $stable(o_status))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request taken while a result is pending");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_data == 16'h0000)
        else $error("error result carries data");

    a_value_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_VALUE |-> o_last)
        else $error("illegal value result not last");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_ADDR || o_status == ST_VALUE)
        else $error("bad status code");

endmodule

bind modbus_register_bank mrb_checker u_mrb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_status (o_status),
    .o_data   (o_data),
    .o_last   (o_last)
);

/* tb/sv/modbus_register_bank_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for modbus_register_bank: drives requests, predicts
// results with its own model of the four stores; depends on mrb_pkg and the block
module modbus_register_bank_tb;
    import mrb_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] data;
        logic        last;
    } bank_result_t;

    // holds the bank's state and the results still owed
    class bank_scoreboard;
        bit          coil_bits[2048];
        bit          disc_bits[2048];
        logic [15:0] ireg_words[256];
        logic [15:0] hold_words[256];
        int unsigned size_cfg[4];
        int unsigned run_left;
        int unsigned run_ptr;
        logic [1:0]  run_status;
        bank_result_t owed[$];
        int          errors;

        function void reset_state();
            foreach (coil_bits[i]) coil_bits[i] = 0;
            foreach (disc_bits[i]) disc_bits[i] = 0;
            foreach (ireg_words[i]) ireg_words[i] = '0;
            foreach (hold_words[i]) hold_words[i] = '0;
            size_cfg = '{2048, 2048, 256, 256};
            run_left = 0;
            run_ptr = 0;
            run_status = ST_OK;
            owed.delete();
            errors = 0;
        endfunction

        function void set_size(logic [1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_COIL_SIZE || idx == CFG_DISC_SIZE) size_cfg[idx] = val;
            else size_cfg[idx] = val[8:0];
        endfunction

        function int unsigned depth_of(logic [1:0] tbl);
            return (tbl == TBL_COIL || tbl == TBL_DISC) ? 2048 : 256;
        endfunction

        function int unsigned size_of(logic [1:0] tbl);
            return size_cfg[tbl] < depth_of(tbl) ? size_cfg[tbl] : depth_of(tbl);
        endfunction

        function logic [15:0] elem_get(logic [1:0] tbl, int unsigned idx);
            if (idx >= size_of(tbl)) return '0;
            case (tbl)
                TBL_COIL: return {15'd0, coil_bits[idx]};
                TBL_DISC: return {15'd0, disc_bits[idx]};
                TBL_IREG: return ireg_words[idx];
                default:  return hold_words[idx];
            endcase
        endfunction

        function void elem_set(logic [1:0] tbl, int unsigned idx, logic [15:0] v);
            if (idx >= size_of(tbl)) return;
            case (tbl)
                TBL_COIL: coil_bits[idx] = v[0];
                TBL_DISC: disc_bits[idx] = v[0];
                TBL_IREG: ireg_words[idx] = v;
                default:  hold_words[idx] = v;
            endcase
        endfunction

        function void push(logic [1:0] st, logic [15:0] d, logic l);
            bank_result_t r;
            r.status = st;
            r.data = d;
            r.last = l;
            owed.insert(owed.size(), r);
        endfunction

        // note an accepted request and queue what it should produce
        function void note_request(logic [1:0] cmd, logic [1:0] tbl, logic [15:0] start,
                                   logic [10:0] cnt, logic [15:0] val);
            bit          bits;
            int unsigned sz, nres, take;
            logic [15:0] d, e;
            bits = (tbl == TBL_COIL || tbl == TBL_DISC);
            sz = size_of(tbl);
            if (cmd == CMD_READ) begin
                run_left = 0;
                nres = bits ? (cnt + 15) / 16 : cnt;
                if (cnt == 0 || nres > 64) push(ST_VALUE, '0, 1'b1);
                else if (start + cnt > sz) push(ST_ADDR, '0, 1'b1);
                else begin
                    for (int r = 0; r < nres; r++) begin
                        d = '0;
                        if (bits) begin
                            for (int k = 0; k < 16; k++) begin
                                if (r * 16 + k < cnt) begin
                                    e = elem_get(tbl, start + r * 16 + k);
                                    d[k] = e[0];
                                end
                            end
                        end else begin
                            d = elem_get(tbl, start + r);
                        end
                        push(ST_OK, d, r + 1 == nres);
                    end
                end
            end else if (cmd == CMD_WRITE1) begin
                run_left = 0;
                if (start >= sz) push(ST_ADDR, '0, 1'b1);
                else if (bits && val != COIL_ON && val != COIL_OFF) push(ST_VALUE, '0, 1'b1);
                else begin
                    elem_set(tbl, start, bits ? {15'd0, val == COIL_ON} : val);
                    push(ST_OK, '0, 1'b1);
                end
            end else if (cmd == CMD_WRITEM) begin
                if (run_left == 0) begin
                    if (cnt == 0) begin
                        push(ST_VALUE, '0, 1'b1);
                        return;
                    end
                    run_status = (start + cnt > sz) ? ST_ADDR : ST_OK;
                    run_ptr = start;
                    run_left = cnt;
                end
                take = bits ? 16 : 1;
                if (take > run_left) take = run_left;
                if (run_status == ST_OK)
                    for (int k = 0; k < take; k++)
                        elem_set(tbl, (run_ptr + k) & 16'hFFFF,
                                 bits ? {15'd0, val[k]} : val);
                run_ptr = (run_ptr + take) & 16'hFFFF;
                run_left = run_left - take;
                push(run_status, '0, run_left == 0);
            end else begin
                push(ST_VALUE, '0, 1'b1);
            end
        endfunction

        function void check_result(logic [1:0] st, logic [15:0] d, logic l);
            bank_result_t e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result status=%0d data=%h last=%0d", $time, st, d, l);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (d !== e.data) begin
                $display("%0t: data expected %h actual %h", $time, e.data, d);
                errors++;
            end
            if (l !== e.last) begin
                $display("%0t: last expected %0d actual %0d", $time, e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    logic [1:0]       req_cmd;
    logic [1:0]       req_tbl;
    logic [15:0]      req_start;
    logic [10:0]      req_count;
    logic [15:0]      req_value;
    logic             res_valid;
    logic             res_stall;
    logic [1:0]       res_status;
    logic [15:0]      res_data;
    logic             res_last;
    logic             cfg_we;
    logic [1:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_wdata;

    bank_scoreboard sb;
    bit             hold_off;   // forces a long receiver stall
    bit             stall_busy; // not read anywhere in the bench

    modbus_register_bank dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (req_valid),
        .o_stall     (req_stall),
        .i_command   (req_cmd),
        .i_table_req (req_tbl),
        .i_start_req (req_start),
        .i_count     (req_count),
        .i_value     (req_value),
        .o_valid     (res_valid),
        .i_stall     (res_stall),
        .o_status    (res_status),
        .o_data      (res_data),
        .o_last      (res_last),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // requests and results are taken at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_valid && !req_stall)
                sb.note_request(req_cmd, req_tbl, req_start, req_count, req_value);
            if (res_valid && !res_stall)
                sb.check_result(res_status, res_data, res_last);
        end
    end

    // receiver stall pattern: quiet stretches, then bursty stalls
    initial begin : stall_gen
        int phase;
        res_stall = 1'b0;
        phase = 0;
        forever begin
            @(negedge clk);
            if (hold_off) res_stall <= 1'b1;
            else begin
                phase = (phase + 1) % 400;
                if (phase < 80) res_stall <= 1'b0;
                else res_stall <= ($urandom_range(0, 99) < 40);
            end
        end
    end

    // present one request and hold it until taken
    task automatic send_request(logic [1:0] cmd, logic [1:0] tbl, logic [15:0] start,
                                logic [10:0] cnt, logic [15:0] val);
        req_valid <= 1'b1;
        req_cmd   <= cmd;
        req_tbl   <= tbl;
        req_start <= start;
        req_count <= cnt;
        req_value <= val;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (sb.owed.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_size(logic [1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_size(idx, val);
    endtask

    // one request with random content, biased toward in-range runs
    task automatic random_request();
        logic [1:0]  cmd, tbl;
        logic [15:0] start, val;
        logic [10:0] cnt;
        int unsigned sz, pick, n;
        tbl = 2'($urandom_range(0, 3));
        sz = sb.size_of(tbl);
        pick = $urandom_range(0, 99);
        val = 16'($urandom);
        if (pick < 10) begin
            // noise: any field value at all
            cmd = 2'($urandom_range(0, 3));
            start = 16'($urandom);
            cnt = 11'($urandom);
            send_request(cmd, tbl, start, cnt, val);
        end else if (pick < 45) begin
            cnt = (tbl < 2) ? 11'($urandom_range(1, 96)) : 11'($urandom_range(1, 12));
            start = (sz > cnt) ? 16'($urandom_range(0, sz - cnt)) : 16'd0;
            send_request(CMD_READ, tbl, start, cnt, val);
        end else if (pick < 70) begin
            start = (sz > 0) ? 16'($urandom_range(0, sz - 1)) : 16'd0;
            if (tbl < 2 && $urandom_range(0, 7) != 0) val = $urandom_range(0, 1) ? COIL_ON : COIL_OFF;
            send_request(CMD_WRITE1, tbl, start, cnt, val);
        end else begin
            // write run, sometimes broken off early
            cnt = (tbl < 2) ? 11'($urandom_range(1, 64)) : 11'($urandom_range(1, 6));
            start = (sz > cnt && $urandom_range(0, 9) != 0) ? 16'($urandom_range(0, sz - cnt))
                                                             : 16'($urandom);
            n = (tbl < 2) ? (cnt + 15) / 16 : cnt;
            if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
            for (int k = 0; k < n; k++) begin
                send_request(CMD_WRITEM, tbl, start, cnt, 16'($urandom));
            end
        end
    endtask

    initial begin : timeout
        #60ms;
        $display("modbus_register_bank_tb NOT OK");
        $finish;
    end

    initial begin : main
        sb = new();
        sb.reset_state();
        hold_off = 1'b0;
        req_valid = 1'b0;
        req_cmd = '0;
        req_tbl = '0;
        req_start = '0;
        req_count = '0;
        req_value = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every command, limits and error cases
        send_request(CMD_WRITE1, TBL_COIL, 16'd0, 11'd0, COIL_ON);
        send_request(CMD_WRITE1, TBL_COIL, 16'd2047, 11'd0, COIL_ON);
        send_request(CMD_WRITE1, TBL_COIL, 16'd5, 11'd0, 16'h1234);    // bad coil value
        send_request(CMD_WRITE1, TBL_HOLD, 16'd255, 11'd0, 16'hFFFF);
        send_request(CMD_WRITE1, TBL_IREG, 16'd256, 11'd0, 16'hAAAA);  // past end
        send_request(CMD_WRITE1, TBL_DISC, 16'hFFFF, 11'd0, COIL_ON);
        send_request(CMD_READ, TBL_COIL, 16'd0, 11'd0, 16'h0);         // zero count
        send_request(CMD_READ, TBL_COIL, 16'd2032, 11'd16, 16'h0);
        send_request(CMD_READ, TBL_COIL, 16'd3, 11'd1024, 16'h0);      // unaligned, 64 results
        send_request(CMD_READ, TBL_COIL, 16'd0, 11'd1025, 16'h0);      // too many results
        send_request(CMD_READ, TBL_COIL, 16'd2040, 11'd9, 16'h0);      // past end
        send_request(CMD_READ, TBL_HOLD, 16'd250, 11'd6, 16'h0);
        send_request(CMD_READ, TBL_IREG, 16'd0, 11'd65, 16'h0);
        send_request(CMD_READ, TBL_DISC, 16'hFFFF, 11'd2000, 16'h0);
        send_request(CMD_WRITEM, TBL_COIL, 16'd7, 11'd20, 16'hA5C3);
        send_request(CMD_WRITEM, TBL_COIL, 16'd7, 11'd20, 16'hFFFF);
        send_request(CMD_READ, TBL_COIL, 16'd5, 11'd24, 16'h0);
        send_request(CMD_WRITEM, TBL_HOLD, 16'd0, 11'd0, 16'h0);       // zero count run
        send_request(CMD_WRITEM, TBL_HOLD, 16'd254, 11'd3, 16'h1111);  // erroring run
        send_request(CMD_WRITEM, TBL_HOLD, 16'd254, 11'd3, 16'h2222);
        send_request(CMD_WRITEM, TBL_IREG, 16'd10, 11'd3, 16'h5A5A);
        send_request(CMD_WRITE1, TBL_IREG, 16'd11, 11'd0, 16'h0001);   // cancels run
        send_request(CMD_READ, TBL_IREG, 16'd9, 11'd4, 16'h0);
        send_request(2'd3, TBL_HOLD, 16'hFFFF, 11'h7FF, 16'hFFFF);     // unknown command
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            repeat (10) random_request();
        join
        wait_drained();

        // random phases through several size settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_size(CFG_COIL_SIZE, 12'd0);
                    write_size(CFG_DISC_SIZE, 12'hFFF);
                    write_size(CFG_IREG_SIZE, 12'd0);
                    write_size(CFG_HOLD_SIZE, 12'h1FF);
                end
                1: begin
                    write_size(CFG_COIL_SIZE, 12'd100);
                    write_size(CFG_DISC_SIZE, 12'd1);
                    write_size(CFG_IREG_SIZE, 12'd1);
                    write_size(CFG_HOLD_SIZE, 12'd17);
                end
                2: begin
                    write_size(CFG_COIL_SIZE, 12'($urandom_range(0, 4095)));
                    write_size(CFG_DISC_SIZE, 12'($urandom_range(0, 4095)));
                    write_size(CFG_IREG_SIZE, 12'($urandom_range(0, 511)));
                    write_size(CFG_HOLD_SIZE, 12'($urandom_range(0, 511)));
                end
                default: begin
                    write_size(CFG_COIL_SIZE, 12'd2048);
                    write_size(CFG_DISC_SIZE, 12'd2048);
                    write_size(CFG_IREG_SIZE, 12'd256);
                    write_size(CFG_HOLD_SIZE, 12'd256);
                end
            endcase
            for (int b = 0; b < 10; b++) begin
                int burst;
                burst = $urandom_range(1, 5);
                repeat (burst) random_request();
                if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
            end
            wait_drained();
        end

        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("modbus_register_bank_tb OK");
        end else begin
            $display("modbus_register_bank_tb NOT OK");
        end
        $finish;
    end
endmodule
